/* sv/mid_pkg.sv */
// ----------------------------------------------------------------------------
// MIPS32 instruction decoder package
// Mnemonic codes, opcode and function codes, and the decoded result record.
// ----------------------------------------------------------------------------
`default_nettype none

package mid_pkg;

  localparam int unsigned WORD_W = 32;

  typedef enum logic [5:0] {
    MN_UNKNOWN = 6'd0,
    MN_NOP     = 6'd1,
    MN_BREAK   = 6'd2,
    MN_SLL     = 6'd3,
    MN_SRL     = 6'd4,
    MN_SRA     = 6'd5,
    MN_SLLV    = 6'd6,
    MN_SRLV    = 6'd7,
    MN_SRAV    = 6'd8,
    MN_JR      = 6'd9,
    MN_JALR    = 6'd10,
    MN_SYSCALL = 6'd11,
    MN_MFHI    = 6'd12,
    MN_MTHI    = 6'd13,
    MN_MFLO    = 6'd14,
    MN_MTLO    = 6'd15,
    MN_MULT    = 6'd16,
    MN_MULTU   = 6'd17,
    MN_DIV     = 6'd18,
    MN_DIVU    = 6'd19,
    MN_ADD     = 6'd20,
    MN_ADDU    = 6'd21,
    MN_SUB     = 6'd22,
    MN_SUBU    = 6'd23,
    MN_AND     = 6'd24,
    MN_OR      = 6'd25,
    MN_XOR     = 6'd26,
    MN_NOR     = 6'd27,
    MN_SLT     = 6'd28,
    MN_SLTU    = 6'd29,
    MN_BGEZ    = 6'd30,
    MN_BLTZ    = 6'd31,
    MN_J       = 6'd32,
    MN_JAL     = 6'd33,
    MN_BEQ     = 6'd34,
    MN_BNE     = 6'd35,
    MN_BLEZ    = 6'd36,
    MN_BGTZ    = 6'd37,
    MN_ADDI    = 6'd38,
    MN_ADDIU   = 6'd39,
    MN_SLTI    = 6'd40,
    MN_SLTIU   = 6'd41,
    MN_ANDI    = 6'd42,
    MN_ORI     = 6'd43,
    MN_XORI    = 6'd44,
    MN_LUI     = 6'd45,
    MN_LB      = 6'd46,
    MN_LH      = 6'd47,
    MN_LW      = 6'd48,
    MN_LBU     = 6'd49,
    MN_LHU     = 6'd50,
    MN_SB      = 6'd51,
    MN_SH      = 6'd52,
    MN_SW      = 6'd53,
    MN_ERET    = 6'd54
  } mnem_t;

  // Primary opcodes
  localparam logic [5:0] OP_SPECIAL = 6'b000000;
  localparam logic [5:0] OP_REGIMM  = 6'b000001;
  localparam logic [5:0] OP_J       = 6'b000010;
  localparam logic [5:0] OP_JAL     = 6'b000011;
  localparam logic [5:0] OP_BEQ     = 6'b000100;
  localparam logic [5:0] OP_BNE     = 6'b000101;
  localparam logic [5:0] OP_BLEZ    = 6'b000110;
  localparam logic [5:0] OP_BGTZ    = 6'b000111;
  localparam logic [5:0] OP_ADDI    = 6'b001000;
  localparam logic [5:0] OP_ADDIU   = 6'b001001;
  localparam logic [5:0] OP_SLTI    = 6'b001010;
  localparam logic [5:0] OP_SLTIU   = 6'b001011;
  localparam logic [5:0] OP_ANDI    = 6'b001100;
  localparam logic [5:0] OP_ORI     = 6'b001101;
  localparam logic [5:0] OP_XORI    = 6'b001110;
  localparam logic [5:0] OP_LUI     = 6'b001111;
  localparam logic [5:0] OP_LB      = 6'b100000;
  localparam logic [5:0] OP_LH      = 6'b100001;
  localparam logic [5:0] OP_LW      = 6'b100011;
  localparam logic [5:0] OP_LBU     = 6'b100100;
  localparam logic [5:0] OP_LHU     = 6'b100101;
  localparam logic [5:0] OP_SB      = 6'b101000;
  localparam logic [5:0] OP_SH      = 6'b101001;
  localparam logic [5:0] OP_SW      = 6'b101011;

  // Function codes of the special opcode
  localparam logic [5:0] FN_SLL     = 6'd0;
  localparam logic [5:0] FN_SRL     = 6'd2;
  localparam logic [5:0] FN_SRA     = 6'd3;
  localparam logic [5:0] FN_SLLV    = 6'd4;
  localparam logic [5:0] FN_SRLV    = 6'd6;
  localparam logic [5:0] FN_SRAV    = 6'd7;
  localparam logic [5:0] FN_JR      = 6'd8;
  localparam logic [5:0] FN_JALR    = 6'd9;
  localparam logic [5:0] FN_SYSCALL = 6'd12;
  localparam logic [5:0] FN_BREAK   = 6'd13;
  localparam logic [5:0] FN_MFHI    = 6'd16;
  localparam logic [5:0] FN_MTHI    = 6'd17;
  localparam logic [5:0] FN_MFLO    = 6'd18;
  localparam logic [5:0] FN_MTLO    = 6'd19;
  localparam logic [5:0] FN_MULT    = 6'd24;
  localparam logic [5:0] FN_MULTU   = 6'd25;
  localparam logic [5:0] FN_DIV     = 6'd26;
  localparam logic [5:0] FN_DIVU    = 6'd27;
  localparam logic [5:0] FN_ADD     = 6'd32;
  localparam logic [5:0] FN_ADDU    = 6'd33;
  localparam logic [5:0] FN_SUB     = 6'd34;
  localparam logic [5:0] FN_SUBU    = 6'd35;
  localparam logic [5:0] FN_AND     = 6'd36;
  localparam logic [5:0] FN_OR      = 6'd37;
  localparam logic [5:0] FN_XOR     = 6'd38;
  localparam logic [5:0] FN_NOR     = 6'd39;
  localparam logic [5:0] FN_SLT     = 6'd42;
  localparam logic [5:0] FN_SLTU    = 6'd43;

  // Regimm rt selector for bgez; every other rt value means bltz.
  localparam logic [4:0] RT_BGEZ = 5'd1;

  // The single word that decodes as eret.
  localparam logic [WORD_W-1:0] ERET_WORD = 32'h4200_0018;

  // Listing address step per instruction.
  localparam logic [WORD_W-1:0] ADDR_STEP = 32'd4;

  typedef struct packed {
    mnem_t             mnemonic_code;
    logic [4:0]        src_reg;
    logic [4:0]        tgt_reg;
    logic [4:0]        dst_reg;
    logic [4:0]        shift_amount;
    logic [15:0]       immediate;
    logic [19:0]       break_code;
    logic              has_target;
    logic [WORD_W-1:0] target_address;
    logic [WORD_W-1:0] instr_address;
  } res_t;

  function automatic mnem_t rtype_code(input logic [5:0] fn);
    mnem_t code;
    case (fn)
      FN_SLL:     code = MN_SLL;
      FN_SRL:     code = MN_SRL;
      FN_SRA:     code = MN_SRA;
      FN_SLLV:    code = MN_SLLV;
      FN_SRLV:    code = MN_SRLV;
      FN_SRAV:    code = MN_SRAV;
      FN_JR:      code = MN_JR;
      FN_JALR:    code = MN_JALR;
      FN_SYSCALL: code = MN_SYSCALL;
      FN_BREAK:   code = MN_BREAK;
      FN_MFHI:    code = MN_MFHI;
      FN_MTHI:    code = MN_MTHI;
      FN_MFLO:    code = MN_MFLO;
      FN_MTLO:    code = MN_MTLO;
      FN_MULT:    code = MN_MULT;
      FN_MULTU:   code = MN_MULTU;
      FN_DIV:     code = MN_DIV;
      FN_DIVU:    code = MN_DIVU;
      FN_ADD:     code = MN_ADD;
      FN_ADDU:    code = MN_ADDU;
      FN_SUB:     code = MN_SUB;
      FN_SUBU:    code = MN_SUBU;
      FN_AND:     code = MN_AND;
      FN_OR:      code = MN_OR;
      FN_XOR:     code = MN_XOR;
      FN_NOR:     code = MN_NOR;
      FN_SLT:     code = MN_SLT;
      FN_SLTU:    code = MN_SLTU;
      default:    code = MN_UNKNOWN;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

/* sv/mid_if.sv */
// ----------------------------------------------------------------------------
// MIPS32 instruction decoder channels
// Valid/ready interfaces for the instruction request and decoded result.
// ----------------------------------------------------------------------------
`default_nettype none

interface mid_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] instr_word;
  logic        restart;

  modport source (output valid, output instr_word, output restart, input ready);
  modport sink   (input valid, input instr_word, input restart, output ready);
endinterface

interface mid_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  mnemonic_code;
  logic [4:0]  src_reg;
  logic [4:0]  tgt_reg;
  logic [4:0]  dst_reg;
  logic [4:0]  shift_amount;
  logic [15:0] immediate;
  logic [19:0] break_code;
  logic        has_target;
  logic [31:0] target_address;
  logic [31:0] instr_address;

  modport source (
    output valid, output mnemonic_code, output src_reg, output tgt_reg,
    output dst_reg, output shift_amount, output immediate, output break_code,
    output has_target, output target_address, output instr_address,
    input ready
  );
  modport sink (
    input valid, input mnemonic_code, input src_reg, input tgt_reg,
    input dst_reg, input shift_amount, input immediate, input break_code,
    input has_target, input target_address, input instr_address,
    output ready
  );
endinterface

`default_nettype wire

/* sv/mid_pc.sv */
// ----------------------------------------------------------------------------
// MIPS32 decoder listing address counter
// Gives the listing address of an accepted request and steps it by four.
// ----------------------------------------------------------------------------
`default_nettype none

module mid_pc (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       accept,
  input  logic                       restart,
  output logic [mid_pkg::WORD_W-1:0] pc
);
  import mid_pkg::*;

  logic [WORD_W-1:0] next_addr_r;
  logic [WORD_W-1:0] next_addr_nxt;

  // A restart places this instruction at address zero.
  assign pc            = restart ? '0 : next_addr_r;
  assign next_addr_nxt = pc + ADDR_STEP;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_addr_r <= '0;
    end else if (accept) begin
      next_addr_r <= next_addr_nxt;
    end
  end

endmodule

`default_nettype wire

/* sv/mid_decode.sv */
// ----------------------------------------------------------------------------
// MIPS32 instruction field decoder
// Mnemonic lookup, raw field split and branch or jump target computation.
// ----------------------------------------------------------------------------
`default_nettype none

module mid_decode (
  input  logic [mid_pkg::WORD_W-1:0] word,
  input  logic [mid_pkg::WORD_W-1:0] pc,
  output mid_pkg::res_t              res
);
  import mid_pkg::*;

  logic [5:0]        op;
  logic [WORD_W-1:0] br_off;
  logic [WORD_W-1:0] br_tgt;
  logic [WORD_W-1:0] jmp_tgt;
  mnem_t             code;
  logic              has_t;
  logic [WORD_W-1:0] tgt;

  assign op      = word[31:26];
  assign br_off  = {{14{word[15]}}, word[15:0], 2'b00};
  assign br_tgt  = pc + ADDR_STEP + br_off;
  assign jmp_tgt = {4'b0000, word[25:0], 2'b00};

  always_comb begin
    code  = MN_UNKNOWN;
    has_t = 1'b0;
    tgt   = '0;
    if (word == '0) begin
      code = MN_NOP;
    end else begin
      case (op)
        OP_SPECIAL: code = rtype_code(word[5:0]);
        OP_REGIMM: begin
          code  = (word[20:16] == RT_BGEZ) ? MN_BGEZ : MN_BLTZ;
          has_t = 1'b1;
          tgt   = br_tgt;
        end
        OP_J: begin
          code  = MN_J;
          has_t = 1'b1;
          tgt   = jmp_tgt;
        end
        OP_JAL: begin
          code  = MN_JAL;
          has_t = 1'b1;
          tgt   = jmp_tgt;
        end
        OP_BEQ, OP_BNE, OP_BLEZ, OP_BGTZ: begin
          case (op)
            OP_BEQ:  code = MN_BEQ;
            OP_BNE:  code = MN_BNE;
            OP_BLEZ: code = MN_BLEZ;
            default: code = MN_BGTZ;
          endcase
          has_t = 1'b1;
          tgt   = br_tgt;
        end
        OP_ADDI:  code = MN_ADDI;
        OP_ADDIU: code = MN_ADDIU;
        OP_SLTI:  code = MN_SLTI;
        OP_SLTIU: code = MN_SLTIU;
        OP_ANDI:  code = MN_ANDI;
        OP_ORI:   code = MN_ORI;
        OP_XORI:  code = MN_XORI;
        OP_LUI:   code = MN_LUI;
        OP_LB:    code = MN_LB;
        OP_LH:    code = MN_LH;
        OP_LW:    code = MN_LW;
        OP_LBU:   code = MN_LBU;
        OP_LHU:   code = MN_LHU;
        OP_SB:    code = MN_SB;
        OP_SH:    code = MN_SH;
        OP_SW:    code = MN_SW;
        default: begin
          if (word == ERET_WORD) begin
            code = MN_ERET;
          end
        end
      endcase
    end
  end

  always_comb begin
    res.mnemonic_code  = code;
    res.src_reg        = word[25:21];
    res.tgt_reg        = word[20:16];
    res.dst_reg        = word[15:11];
    res.shift_amount   = word[10:6];
    res.immediate      = word[15:0];
    res.break_code     = word[25:6];
    res.has_target     = has_t;
    res.target_address = tgt;
    res.instr_address  = pc;
  end

endmodule

`default_nettype wire

/* sv/mips32_instruction_decoder_top.sv */
// ----------------------------------------------------------------------------
// MIPS32 instruction decoder
// Decodes one instruction word per request into mnemonic, fields and target.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake     Carries
//   in_ch     sink       valid/ready   instr_word, restart
//   out_ch    source     valid/ready   mnemonic, raw fields, target, address
//
// One request is taken every cycle while the result side does not stall; an
// accepted request passes through the input register, then the result
// register. The decode and the 32-bit branch target sum sit between the two.
// Reset clears both valid flags and sets the listing address to zero.
// A stalled result register still frees the input register when it drains,
// and the input side stalls only when both registers hold waiting requests.
// ----------------------------------------------------------------------------
`default_nettype none

module mips32_instruction_decoder_top (
  input logic clk,
  input logic rst_n,
  mid_in_if.sink    in_ch,
  mid_out_if.source out_ch
);
  import mid_pkg::*;

  // Input stage: the listing address is assigned here, in request order,
  // so the counter never has to look at later stages.
  logic              s1_valid_r;
  logic [WORD_W-1:0] s1_word_r;
  logic [WORD_W-1:0] s1_pc_r;

  // Result stage.
  logic              out_valid_r;
  res_t              out_res_r;

  logic              in_fire;
  logic              s1_adv;
  logic [WORD_W-1:0] in_pc;
  res_t              dec_res;

  // The input register moves forward whenever the result register is
  // empty or is being drained in the same cycle.
  assign s1_adv      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign in_fire     = in_ch.valid && in_ch.ready;

  mid_pc u_pc (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (in_fire),
    .restart (in_ch.restart),
    .pc      (in_pc)
  );

  mid_decode u_decode (
    .word (s1_word_r),
    .pc   (s1_pc_r),
    .res  (dec_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_word_r <= in_ch.instr_word;
      s1_pc_r   <= in_pc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_res_r <= dec_res;
    end
  end

  // Result channel unpacking.
  assign out_ch.valid          = out_valid_r;
  assign out_ch.mnemonic_code  = out_res_r.mnemonic_code;
  assign out_ch.src_reg        = out_res_r.src_reg;
  assign out_ch.tgt_reg        = out_res_r.tgt_reg;
  assign out_ch.dst_reg        = out_res_r.dst_reg;
  assign out_ch.shift_amount   = out_res_r.shift_amount;
  assign out_ch.immediate      = out_res_r.immediate;
  assign out_ch.break_code     = out_res_r.break_code;
  assign out_ch.has_target     = out_res_r.has_target;
  assign out_ch.target_address = out_res_r.target_address;
  assign out_ch.instr_address  = out_res_r.instr_address;

  // A request that moves out of the input register is in the result
  // register on the next cycle.
  a_adv_lands: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("advanced request did not reach the result register");

  // A held input register keeps its word and address.
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |=> (s1_valid_r && $stable(s1_word_r) && $stable(s1_pc_r)))
    else $error("stalled input register changed");

  // A restart request is listed at address zero.
  a_restart_pc: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_ch.restart) |=> (s1_pc_r == '0))
    else $error("restart request not placed at address zero");

  // Back-to-back requests without restart are four bytes apart.
  a_pc_step: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !in_ch.restart && $past(in_fire)) |=>
      (s1_pc_r == $past(s1_pc_r) + ADDR_STEP))
    else $error("listing address did not step by four");

endmodule

`default_nettype wire

/* test/mips32_instruction_decoder_top_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// MIPS32 instruction decoder regression
// Drives instruction words through the request channel and checks each
// decoded result against a cycle-free decoder model kept in the bench. A
// short table of hand-picked words comes first, followed by weighted random
// instruction streams under four handshake pressure phases.
// ----------------------------------------------------------------------------

module mips32_instruction_decoder_top_test;

  import mid_pkg::*;

  // Opcode and function values the decoder must reject; the package does not
  // name them because they are not part of the supported set.
  localparam logic [5:0] OP_LWL     = 6'b100010;
  localparam logic [5:0] FN_UNUSED  = 6'd1;

  localparam int PHASES       = 4;
  localparam int RANDOM_PER   = 388;   // random requests per phase
  localparam int DIRECTED_N   = 25;
  localparam int DRAIN_CYCLES = 8;
  localparam int QUIET_LIMIT  = 2000;  // cycles without any handshake
  localparam int REPORT_MAX   = 10;

  // One row of stimulus. When pinned is set, the decoded mnemonic, branch
  // flag, target and listing address are taken from the row itself rather
  // than from the bench decoder; the raw fields always come from the decoder.
  typedef struct packed {
    logic [31:0] word;
    logic        restart;
    logic        pinned;
    mnem_t       code;
    logic        has_target;
    logic [31:0] target;
    logic [31:0] addr;
  } stim_row_t;

  logic clk;
  logic rst_n;

  mid_in_if  in_ch ();
  mid_out_if out_ch ();

  mips32_instruction_decoder_top uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // The directed table. The listing address starts at zero after reset and
  // steps by four, so the pinned addresses can be read straight off the row
  // index, up to the restart row which sends the listing back to zero.
  stim_row_t directed_tbl [DIRECTED_N] = '{
    // All-zero word is nop, not sll.
    '{32'h0000_0000, 1'b0, 1'b1, MN_NOP,     1'b0, 32'h0, 32'd0},
    // All-ones word: opcode 63 is not decoded.
    '{32'hFFFF_FFFF, 1'b0, 1'b1, MN_UNKNOWN, 1'b0, 32'h0, 32'd4},
    // Break with every code bit set.
    '{{OP_SPECIAL, 20'hF_FFFF, FN_BREAK}, 1'b0, 1'b1, MN_BREAK, 1'b0, 32'h0, 32'd8},
    // Special opcode with a function code outside the table.
    '{{OP_SPECIAL, 20'h0_0000, FN_UNUSED}, 1'b0, 1'b1, MN_UNKNOWN, 1'b0, 32'h0, 32'd12},
    '{{OP_SPECIAL, 5'd31, 5'd31, 5'd31, 5'd31, FN_SLTU}, 1'b0, 1'b0, MN_UNKNOWN,
      1'b0, 32'h0, 32'h0},
    '{{OP_SPECIAL, 5'd0, 5'd2, 5'd2, 5'd2, FN_SLL}, 1'b0, 1'b0, MN_UNKNOWN,
      1'b0, 32'h0, 32'h0},
    // Eret is a single exact word; one bit off it is no longer decoded.
    '{ERET_WORD,           1'b0, 1'b1, MN_ERET,    1'b0, 32'h0, 32'd24},
    '{ERET_WORD ^ 32'h1,   1'b0, 1'b1, MN_UNKNOWN, 1'b0, 32'h0, 32'd28},
    // Regimm: rt of one is bgez, any other rt is bltz. Offsets at both ends.
    '{{OP_REGIMM, 5'd3, RT_BGEZ, 16'h7FFF}, 1'b0, 1'b0, MN_UNKNOWN, 1'b0, 32'h0, 32'h0},
    '{{OP_REGIMM, 5'd0, 5'd0, 16'h8000},    1'b0, 1'b0, MN_UNKNOWN, 1'b0, 32'h0, 32'h0},
    '{{OP_REGIMM, 5'd31, 5'd31, 16'hFFFF},  1'b0, 1'b0, MN_UNKNOWN, 1'b0, 32'h0, 32'h0},
    // Restart with a backward branch: the target wraps below address zero.
    '{{OP_BEQ, 5'd1, 5'd2, 16'hFFFE}, 1'b1, 1'b1, MN_BEQ, 1'b1, 32'hFFFF_FFFC, 32'd0},
    // Jumps keep the upper four bits clear.
    '{{OP_J, 26'h3FF_FFFF}, 1'b0, 1'b1, MN_J,   1'b1, 32'h0FFF_FFFC, 32'd4},
    '{{OP_JAL, 26'h000_0000}, 1'b0, 1'b1, MN_JAL, 1'b1, 32'h0, 32'd8},
    '{{OP_BNE, 5'd7, 5'd9, 16'h0001},   1'b0, 1'b0, MN_UNKNOWN, 1'b0, 32'h0, 32'h0},
    '{{OP_BLEZ, 5'd4, 5'd0, 16'h8000},  1'b0, 1'b0, MN_UNKNOWN, 1'b0, 32'h0, 32'h0},
    '{{OP_BGTZ, 5'd5, 5'd0, 16'h7FFF},  1'b0, 1'b0, MN_UNKNOWN, 1'b0, 32'h0, 32'h0},
    '{{OP_ADDI, 5'd31, 5'd0, 16'h8000}, 1'b0, 1'b0, MN_UNKNOWN, 1'b0, 32'h0, 32'h0},
    '{{OP_ORI, 5'd1, 5'd2, 16'hFFFF},   1'b0, 1'b0, MN_UNKNOWN, 1'b0, 32'h0, 32'h0},
    '{{OP_LUI, 5'd0, 5'd8, 16'h1234},   1'b0, 1'b0, MN_UNKNOWN, 1'b0, 32'h0, 32'h0},
    '{{OP_LW, 5'd29, 5'd31, 16'hFFFC},  1'b0, 1'b0, MN_UNKNOWN, 1'b0, 32'h0, 32'h0},
    '{{OP_SW, 5'd29, 5'd16, 16'h0000},  1'b0, 1'b0, MN_UNKNOWN, 1'b0, 32'h0, 32'h0},
    // A load opcode in the gap of the memory group is not decoded.
    '{{OP_LWL, 26'h2AA_AAAA}, 1'b0, 1'b1, MN_UNKNOWN, 1'b0, 32'h0, 32'd44},
    '{{OP_LHU, 5'd2, 5'd3, 16'h5555},   1'b0, 1'b0, MN_UNKNOWN, 1'b0, 32'h0, 32'h0},
    '{{OP_SPECIAL, 5'd31, 5'd0, 5'd31, 5'd0, FN_JALR}, 1'b0, 1'b0, MN_UNKNOWN,
      1'b0, 32'h0, 32'h0}
  };

  // Function codes and opcodes the random stream draws from when it builds
  // well-formed instructions.
  logic [5:0] fn_known [28] = '{
    FN_SLL, FN_SRL, FN_SRA, FN_SLLV, FN_SRLV, FN_SRAV, FN_JR, FN_JALR,
    FN_SYSCALL, FN_BREAK, FN_MFHI, FN_MTHI, FN_MFLO, FN_MTLO, FN_MULT,
    FN_MULTU, FN_DIV, FN_DIVU, FN_ADD, FN_ADDU, FN_SUB, FN_SUBU, FN_AND,
    FN_OR, FN_XOR, FN_NOR, FN_SLT, FN_SLTU
  };
  logic [5:0] op_known [23] = '{
    OP_REGIMM, OP_J, OP_JAL, OP_BEQ, OP_BNE, OP_BLEZ, OP_BGTZ, OP_ADDI,
    OP_ADDIU, OP_SLTI, OP_SLTIU, OP_ANDI, OP_ORI, OP_XORI, OP_LUI, OP_LB,
    OP_LH, OP_LW, OP_LBU, OP_LHU, OP_SB, OP_SH, OP_SW
  };

  // Handshake pressure, changed per phase by the main sequence.
  int send_idle_pct;
  int recv_stall_pct;

  // Sideband that travels with the request payload so the checker knows
  // which rows carry literal expectations.
  stim_row_t cur_row;

  // Bench copy of the listing address and the results still owed by the DUT.
  logic [31:0] listing_addr;
  res_t        decoded_fifo [$];

  int          errors;
  int          results_seen;
  int          restarts_seen;
  int          targets_seen;
  int          quiet_cycles;
  bit [54:0]   codes_seen;

  // --------------------------------------------------------------------------
  // Decoder model. Pure function of the word and the address it sits at.
  // --------------------------------------------------------------------------
  function automatic res_t decode_instr(input logic [31:0] word,
                                        input logic [31:0] pc);
    res_t        r;
    logic [31:0] branch_dest;

    r                = '0;
    r.mnemonic_code  = MN_UNKNOWN;
    r.src_reg        = word[25:21];
    r.tgt_reg        = word[20:16];
    r.dst_reg        = word[15:11];
    r.shift_amount   = word[10:6];
    r.immediate      = word[15:0];
    r.break_code     = word[25:6];
    r.instr_address  = pc;

    // Sign-extended word offset, counted from the delay slot.
    branch_dest = pc + ADDR_STEP + {{14{word[15]}}, word[15:0], 2'b00};

    if (word == '0) begin
      r.mnemonic_code = MN_NOP;
    end else begin
      case (word[31:26])
        OP_SPECIAL: begin
          case (word[5:0])
            FN_SLL:     r.mnemonic_code = MN_SLL;
            FN_SRL:     r.mnemonic_code = MN_SRL;
            FN_SRA:     r.mnemonic_code = MN_SRA;
            FN_SLLV:    r.mnemonic_code = MN_SLLV;
            FN_SRLV:    r.mnemonic_code = MN_SRLV;
            FN_SRAV:    r.mnemonic_code = MN_SRAV;
            FN_JR:      r.mnemonic_code = MN_JR;
            FN_JALR:    r.mnemonic_code = MN_JALR;
            FN_SYSCALL: r.mnemonic_code = MN_SYSCALL;
            FN_BREAK:   r.mnemonic_code = MN_BREAK;
            FN_MFHI:    r.mnemonic_code = MN_MFHI;
            FN_MTHI:    r.mnemonic_code = MN_MTHI;
            FN_MFLO:    r.mnemonic_code = MN_MFLO;
            FN_MTLO:    r.mnemonic_code = MN_MTLO;
            FN_MULT:    r.mnemonic_code = MN_MULT;
            FN_MULTU:   r.mnemonic_code = MN_MULTU;
            FN_DIV:     r.mnemonic_code = MN_DIV;
            FN_DIVU:    r.mnemonic_code = MN_DIVU;
            FN_ADD:     r.mnemonic_code = MN_ADD;
            FN_ADDU:    r.mnemonic_code = MN_ADDU;
            FN_SUB:     r.mnemonic_code = MN_SUB;
            FN_SUBU:    r.mnemonic_code = MN_SUBU;
            FN_AND:     r.mnemonic_code = MN_AND;
            FN_OR:      r.mnemonic_code = MN_OR;
            FN_XOR:     r.mnemonic_code = MN_XOR;
            FN_NOR:     r.mnemonic_code = MN_NOR;
            FN_SLT:     r.mnemonic_code = MN_SLT;
            FN_SLTU:    r.mnemonic_code = MN_SLTU;
            default:    r.mnemonic_code = MN_UNKNOWN;
          endcase
        end
        OP_REGIMM: begin
          r.mnemonic_code  = (word[20:16] == RT_BGEZ) ? MN_BGEZ : MN_BLTZ;
          r.has_target     = 1'b1;
          r.target_address = branch_dest;
        end
        OP_J, OP_JAL: begin
          r.mnemonic_code  = (word[31:26] == OP_J) ? MN_J : MN_JAL;
          r.has_target     = 1'b1;
          r.target_address = {4'b0000, word[25:0], 2'b00};
        end
        OP_BEQ, OP_BNE, OP_BLEZ, OP_BGTZ: begin
          case (word[31:26])
            OP_BEQ:  r.mnemonic_code = MN_BEQ;
            OP_BNE:  r.mnemonic_code = MN_BNE;
            OP_BLEZ: r.mnemonic_code = MN_BLEZ;
            default: r.mnemonic_code = MN_BGTZ;
          endcase
          r.has_target     = 1'b1;
          r.target_address = branch_dest;
        end
        OP_ADDI:  r.mnemonic_code = MN_ADDI;
        OP_ADDIU: r.mnemonic_code = MN_ADDIU;
        OP_SLTI:  r.mnemonic_code = MN_SLTI;
        OP_SLTIU: r.mnemonic_code = MN_SLTIU;
        OP_ANDI:  r.mnemonic_code = MN_ANDI;
        OP_ORI:   r.mnemonic_code = MN_ORI;
        OP_XORI:  r.mnemonic_code = MN_XORI;
        OP_LUI:   r.mnemonic_code = MN_LUI;
        OP_LB:    r.mnemonic_code = MN_LB;
        OP_LH:    r.mnemonic_code = MN_LH;
        OP_LW:    r.mnemonic_code = MN_LW;
        OP_LBU:   r.mnemonic_code = MN_LBU;
        OP_LHU:   r.mnemonic_code = MN_LHU;
        OP_SB:    r.mnemonic_code = MN_SB;
        OP_SH:    r.mnemonic_code = MN_SH;
        OP_SW:    r.mnemonic_code = MN_SW;
        default:  r.mnemonic_code = (word == ERET_WORD) ? MN_ERET : MN_UNKNOWN;
      endcase
    end
    return r;
  endfunction

  function automatic string show_result(input res_t r);
    return $sformatf("code=%0d(%s) rs=%0d rt=%0d rd=%0d sa=%0d imm=%h brk=%h br=%b tgt=%h pc=%h",
                     r.mnemonic_code, r.mnemonic_code.name(), r.src_reg, r.tgt_reg,
                     r.dst_reg, r.shift_amount, r.immediate, r.break_code,
                     r.has_target, r.target_address, r.instr_address);
  endfunction

  // --------------------------------------------------------------------------
  // Clock: 4 ns period.
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Result side back-pressure. Ready is redrawn every cycle from the stall
  // percentage of the current phase.
  // --------------------------------------------------------------------------
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Checker. Runs on the rising edge and therefore sees the values that were
  // present just before it, the same values the DUT registers. An accepted
  // request is decoded right away and queued; an accepted result is compared
  // field by field with the oldest queued expectation.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : scoreboard
    logic [31:0] pc;
    res_t        want;
    res_t        got;
    string       diff;
    logic        moved;

    if (!rst_n) begin
      listing_addr = '0;
      quiet_cycles <= 0;
    end else begin
      moved = 1'b0;

      if (in_ch.valid && in_ch.ready) begin
        moved = 1'b1;
        // A restart request sits at address zero; the next one follows it.
        pc   = in_ch.restart ? 32'h0 : listing_addr;
        want = decode_instr(in_ch.instr_word, pc);
        if (cur_row.pinned) begin
          want.mnemonic_code  = cur_row.code;
          want.has_target     = cur_row.has_target;
          want.target_address = cur_row.target;
          want.instr_address  = cur_row.addr;
        end
        decoded_fifo.push_back(want);
        listing_addr = pc + ADDR_STEP;
        if (in_ch.restart) restarts_seen++;
        if (want.has_target) targets_seen++;
      end

      if (out_ch.valid && out_ch.ready) begin
        moved = 1'b1;
        got.mnemonic_code  = mnem_t'(out_ch.mnemonic_code);
        got.src_reg        = out_ch.src_reg;
        got.tgt_reg        = out_ch.tgt_reg;
        got.dst_reg        = out_ch.dst_reg;
        got.shift_amount   = out_ch.shift_amount;
        got.immediate      = out_ch.immediate;
        got.break_code     = out_ch.break_code;
        got.has_target     = out_ch.has_target;
        got.target_address = out_ch.target_address;
        got.instr_address  = out_ch.instr_address;
        if (got.mnemonic_code <= MN_ERET) codes_seen[got.mnemonic_code] = 1'b1;

        if (decoded_fifo.size() == 0) begin
          if (errors < REPORT_MAX)
            $display("%0t: result with no request outstanding: %s", $realtime,
                     show_result(got));
          errors++;
        end else begin
          want = decoded_fifo.pop_front();
          diff = "";
          if (got.mnemonic_code  !== want.mnemonic_code)  diff = {diff, " mnemonic"};
          if (got.src_reg        !== want.src_reg)        diff = {diff, " rs"};
          if (got.tgt_reg        !== want.tgt_reg)        diff = {diff, " rt"};
          if (got.dst_reg        !== want.dst_reg)        diff = {diff, " rd"};
          if (got.shift_amount   !== want.shift_amount)   diff = {diff, " shamt"};
          if (got.immediate      !== want.immediate)      diff = {diff, " imm"};
          if (got.break_code     !== want.break_code)     diff = {diff, " break_code"};
          if (got.has_target     !== want.has_target)     diff = {diff, " has_target"};
          if (got.target_address !== want.target_address) diff = {diff, " target"};
          if (got.instr_address  !== want.instr_address)  diff = {diff, " address"};
          if (diff.len() != 0) begin
            if (errors < REPORT_MAX) begin
              $display("%0t: result %0d differs in%s", $realtime, results_seen, diff);
              $display("  expected %s", show_result(want));
              $display("  actual   %s", show_result(got));
            end
            errors++;
          end
        end
        results_seen++;
      end

      quiet_cycles <= moved ? 0 : quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: a hang anywhere shows up as a long run of cycles in which
  // neither channel completes a handshake.
  // --------------------------------------------------------------------------
  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("%0t: no handshake for %0d cycles, %0d results outstanding", $realtime,
             QUIET_LIMIT, decoded_fifo.size());
    $display("mips32_instruction_decoder_top regression: fail");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Request driver. Called at a rising edge; optionally idles for a random
  // number of cycles, then presents the request and returns at the edge where
  // it is taken, with valid still high so the next request can follow
  // back-to-back without valid dropping.
  // --------------------------------------------------------------------------
  task automatic send_request(input stim_row_t row);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.instr_word <= row.word;
    in_ch.restart    <= row.restart;
    cur_row          <= row;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Hold the request side idle until every decoded result has come back.
  // The task waits on a clock edge before it checks the queue, so valid is never
  // lowered and raised in the same step.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (decoded_fifo.size() != 0);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin : main
    int          ph;
    int          i;
    int          sel;
    logic [31:0] word;
    logic [5:0]  op;
    stim_row_t   row;

    // Every DUT input is known from time zero.
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.instr_word = '0;
    in_ch.restart    = 1'b0;
    cur_row          = '0;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    errors           = 0;
    results_seen     = 0;
    restarts_seen    = 0;
    targets_seen     = 0;
    quiet_cycles     = 0;
    codes_seen       = '0;
    listing_addr     = '0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Four pressure phases: free flow, sender gaps, receiver stalls, and a
    // lighter mix of both. Each ends with the sender held off until the
    // decoder has returned everything it owes.
    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
        default: begin send_idle_pct = 14; recv_stall_pct = 14; end
      endcase

      // The directed rows depend on the listing address starting at zero,
      // so they go first, straight after reset.
      if (ph == 0) begin
        for (i = 0; i < DIRECTED_N; i++) send_request(directed_tbl[i]);
      end

      // Random stream. Most words are well-formed instructions with random
      // operand fields; the rest are the special words, special-opcode words
      // with a random function code, and raw noise.
      for (i = 0; i < RANDOM_PER; i++) begin
        sel  = $urandom_range(99);
        word = $urandom;
        if (sel < 40) begin
          word = {OP_SPECIAL, word[25:6], fn_known[$urandom_range(27)]};
        end else if (sel < 80) begin
          op          = op_known[$urandom_range(22)];
          word[31:26] = op;
          // Half of the regimm words are forced to bgez; the rest keep a random rt.
          if (op == OP_REGIMM && $urandom_range(1) == 1) word[20:16] = RT_BGEZ;
        end else if (sel < 85) begin
          word = ERET_WORD;
        end else if (sel < 88) begin
          word = '0;
        end else if (sel < 92) begin
          word[31:26] = OP_SPECIAL;
        end
        row         = '0;
        row.word    = word;
        row.restart = ($urandom_range(99) < 3);
        send_request(row);
      end

      wait_drained();
    end

    // Everything is back; keep the clock running for DRAIN_CYCLES in case the
    // pipeline produces a result nobody asked for.
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d instructions decoded across four handshake phases: %0d listing restarts,",
             results_seen, restarts_seen);
    $display("%0d branch or jump targets, %0d of 55 mnemonic codes seen, %0d mismatches",
             targets_seen, $countones(codes_seen), errors);

    if (errors == 0 && decoded_fifo.size() == 0) begin
      $display("mips32_instruction_decoder_top regression: pass");
    end else begin
      $display("mips32_instruction_decoder_top regression: fail");
    end
    $finish;
  end

endmodule
